@@ hw/rtl/epoch_calendar_converter_unit_defines.svh @@
// ----------------------------------------------------------------------------
// epoch calendar converter assertion macros
// concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef EPOCH_CALENDAR_CONVERTER_UNIT_DEFINES_SVH
`define EPOCH_CALENDAR_CONVERTER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define ECCU_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("eccu assertion failed");
`define ECCU_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("eccu assertion failed");
`else
`define ECCU_ASSERT_IMP(lbl, ante, cons)
`define ECCU_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

@@ hw/rtl/eccu_pkg.sv @@
// ----------------------------------------------------------------------------
// eccu_pkg
// types, constants and calendar helpers for the epoch calendar converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package eccu_pkg;

	localparam logic [31:0] EPOCH_2000    = 32'd946684800;
	localparam logic [31:0] LAST_SECOND   = 32'd4102444799;
	localparam logic [31:0] SECS_PER_DAY  = 32'd86400;
	localparam logic [31:0] SECS_PER_HOUR = 32'd3600;
	localparam logic [31:0] SECS_PER_MIN  = 32'd60;
	localparam logic [31:0] DAYS_PER_QUAD = 32'd1461;
	localparam logic [31:0] DAYS_PER_WEEK = 32'd7;
	localparam logic [31:0] DAYS_YEAR     = 32'd365;
	localparam logic [31:0] DAYS_LEAP     = 32'd366;
	localparam logic [11:0] FIRST_YEAR    = 12'd2000;
	localparam logic [11:0] LAST_YEAR     = 12'd2099;
	localparam logic [3:0]  MONTHS        = 4'd12;

	localparam logic [4:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic {
		OP_TO_CAL  = 1'b0,
		OP_TO_SECS = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		STATUS_OK    = 2'd0,
		STATUS_UNSET = 2'd1,
		STATUS_RANGE = 2'd2
	} status_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DAYS,
		ST_HOURS,
		ST_MINS,
		ST_QUAD,
		ST_YEARS,
		ST_MONTHS,
		ST_SUMMON,
		ST_MUL,
		ST_ADDT,
		ST_ADDE,
		ST_WDAY,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic        opcode;
		logic [31:0] seconds_in;
		logic [11:0] year_in;
		logic [3:0]  month_in;
		logic [4:0]  day_in;
		logic [4:0]  hour_in;
		logic [5:0]  minute_in;
		logic [5:0]  second_in;
	} req_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] seconds_out;
		logic [11:0] year_out;
		logic [3:0]  month_out;
		logic [4:0]  day_out;
		logic [4:0]  hour_out;
		logic [5:0]  minute_out;
		logic [5:0]  second_out;
		logic [2:0]  weekday;
		logic [3:0]  hour_twelve;
		logic        after_noon;
	} rsp_t;

	function automatic logic [4:0] month_len(input logic [6:0] yoff, input logic [3:0] mon);
		logic [4:0] len;
		if (mon == 4'd2) begin
			len = (yoff[1:0] == 2'b00) ? 5'd29 : 5'd28;
		end else if (mon == 4'd0 || mon > MONTHS) begin
			len = 5'd0;
		end else begin
			len = MONTH_DAYS[mon - 4'd1];
		end
		return len;
	endfunction

endpackage

@@ hw/rtl/epoch_calendar_converter_unit.sv @@
// ----------------------------------------------------------------------------
// epoch calendar converter unit
// unix seconds to calendar fields and back, years 2000 to 2099
// ----------------------------------------------------------------------------
//  channel | signals                   | payload
//  req     | req_valid / req_ready     | req_t  (opcode, seconds or calendar)
//  rsp     | rsp_valid / rsp_ready     | rsp_t  (status, seconds, calendar)
//
//  a shared 33-bit add/subtract unit under a small sequencer; arst_n returns to idle
//  seconds to calendar: restoring divisions and year/month counting;
//  calendar to seconds: month summing and weekday
//  zero, bad or out-of-range input goes straight to ST_DONE; req_ready is high only when idle
//  a finished result waits in the rsp register; a new transaction is taken
//  meanwhile, and its result waits in ST_DONE until the register frees
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "epoch_calendar_converter_unit_defines.svh"

module epoch_calendar_converter_unit
	import eccu_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	state_t      state_q, state_d;
	logic [4:0]  cnt_q;
	logic        rsp_valid_q;
	rsp_t        rsp_q, rsp_c;

	logic [31:0] acc_q;
	logic [14:0] q_q;
	logic [15:0] dn_q;
	logic [6:0]  yoff_q;
	logic [3:0]  mon_q;
	logic [4:0]  day_q;
	logic [4:0]  hour_q;
	logic [5:0]  min_q;
	logic [5:0]  sec_q;
	logic [16:0] tod_q;
	logic [31:0] secs_q;
	status_t     status_q;

	logic        unit_add;
	logic [31:0] opnd;
	logic [32:0] sum_w;
	logic        ge;
	logic        accept;
	logic        rsp_load;
	logic        last;

	logic        zero0, range0;
	logic        y_bad, m_bad, d_bad, t_bad, bad1;
	logic [6:0]  yoff_c;
	logic [15:0] base_c;
	logic [16:0] tod_c;

	assign accept = req_valid && req_ready;
	assign last   = (cnt_q == 5'd0);

	// request checks
	always_comb begin
		zero0  = (req.seconds_in == 32'd0);
		range0 = (req.seconds_in < EPOCH_2000) || (req.seconds_in > LAST_SECOND);
		y_bad  = (req.year_in < FIRST_YEAR) || (req.year_in > LAST_YEAR);
		yoff_c = y_bad ? 7'd0 : 7'(req.year_in - FIRST_YEAR);
		m_bad  = (req.month_in == 4'd0) || (req.month_in > MONTHS);
		d_bad  = (req.day_in == 5'd0) || (req.day_in > month_len(yoff_c, req.month_in));
		t_bad  = (req.hour_in > 5'd23) || (req.minute_in > 6'd59) || (req.second_in > 6'd59);
		bad1   = y_bad || m_bad || d_bad || t_bad;
		base_c = 16'(yoff_c) * 16'(DAYS_YEAR) + 16'((yoff_c + 7'd3) >> 2)
			+ 16'(req.day_in) - 16'd1;
		tod_c  = 17'(req.hour_in) * 17'(SECS_PER_HOUR) + 17'(req.minute_in) * 17'(SECS_PER_MIN)
			+ 17'(req.second_in);
	end

	// shared add/subtract unit
	assign sum_w = unit_add ? ({1'b0, acc_q} + {1'b0, opnd}) : ({1'b0, acc_q} - {1'b0, opnd});
	assign ge    = !sum_w[32];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					if (req.opcode == OP_TO_CAL) begin
						state_d = (zero0 || range0) ? ST_DONE : ST_DAYS;
					end else begin
						state_d = bad1 ? ST_DONE : ST_SUMMON;
					end
				end
			end
			ST_DAYS:   if (last) state_d = ST_HOURS;
			ST_HOURS:  if (last) state_d = ST_MINS;
			ST_MINS:   if (last) state_d = ST_QUAD;
			ST_QUAD:   if (last) state_d = ST_YEARS;
			ST_YEARS:  if (!ge) state_d = ST_MONTHS;
			ST_MONTHS: if (!(mon_q < MONTHS && ge)) state_d = ST_WDAY;
			ST_SUMMON: if (cnt_q >= {1'b0, mon_q}) state_d = ST_MUL;
			ST_MUL:    state_d = ST_ADDT;
			ST_ADDT:   state_d = ST_ADDE;
			ST_ADDE:   state_d = ST_WDAY;
			ST_WDAY:   if (last) state_d = ST_DONE;
			ST_DONE:   if (rsp_load) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// control outputs and unit operand
	always_comb begin
		req_ready = (state_q == ST_IDLE);
		rsp_load  = (state_q == ST_DONE) && (!rsp_valid_q || rsp_ready);
		unit_add  = 1'b0;
		opnd      = 32'd0;
		unique case (state_q)
			ST_DAYS:   opnd = SECS_PER_DAY << cnt_q[3:0];
			ST_HOURS:  opnd = SECS_PER_HOUR << cnt_q[3:0];
			ST_MINS:   opnd = SECS_PER_MIN << cnt_q[3:0];
			ST_QUAD:   opnd = DAYS_PER_QUAD << cnt_q[3:0];
			ST_YEARS:  opnd = (yoff_q[1:0] == 2'b00) ? DAYS_LEAP : DAYS_YEAR;
			ST_MONTHS: opnd = 32'(month_len(yoff_q, mon_q));
			ST_SUMMON: begin
				unit_add = 1'b1;
				opnd     = 32'(month_len(yoff_q, cnt_q[3:0]));
			end
			ST_ADDT: begin
				unit_add = 1'b1;
				opnd     = 32'(tod_q);
			end
			ST_ADDE: begin
				unit_add = 1'b1;
				opnd     = EPOCH_2000;
			end
			ST_WDAY:   opnd = DAYS_PER_WEEK << cnt_q[3:0];
			default:   opnd = 32'd0;
		endcase
	end

	// result fields
	always_comb begin
		rsp_c             = '0;
		rsp_c.status      = status_q;
		rsp_c.seconds_out = secs_q;
		rsp_c.year_out    = FIRST_YEAR;
		rsp_c.hour_twelve = 4'd12;
		if (status_q == STATUS_OK) begin
			rsp_c.year_out    = FIRST_YEAR + 12'(yoff_q);
			rsp_c.month_out   = mon_q;
			rsp_c.day_out     = day_q;
			rsp_c.hour_out    = hour_q;
			rsp_c.minute_out  = min_q;
			rsp_c.second_out  = sec_q;
			rsp_c.weekday     = acc_q[2:0];
			rsp_c.after_noon  = (hour_q >= 5'd12);
			if (hour_q == 5'd0) begin
				rsp_c.hour_twelve = 4'd12;
			end else if (hour_q > 5'd12) begin
				rsp_c.hour_twelve = 4'(hour_q - 5'd12);
			end else begin
				rsp_c.hour_twelve = 4'(hour_q);
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= 5'd0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE:   cnt_q <= (req.opcode == OP_TO_CAL) ? 5'd15 : 5'd1;
				ST_DAYS:   cnt_q <= last ? 5'd4 : cnt_q - 5'd1;
				ST_HOURS:  cnt_q <= last ? 5'd5 : cnt_q - 5'd1;
				ST_MINS:   cnt_q <= last ? 5'd4 : cnt_q - 5'd1;
				ST_QUAD:   cnt_q <= cnt_q - 5'd1;
				ST_MONTHS: cnt_q <= 5'd12;
				ST_SUMMON: cnt_q <= cnt_q + 5'd1;
				ST_ADDE:   cnt_q <= 5'd12;
				ST_WDAY:   cnt_q <= cnt_q - 5'd1;
				default:   cnt_q <= cnt_q;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			rsp_q <= rsp_c;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					q_q <= 15'd0;
					if (req.opcode == OP_TO_CAL) begin
						secs_q   <= req.seconds_in;
						acc_q    <= req.seconds_in - EPOCH_2000;
						status_q <= zero0 ? STATUS_UNSET : (range0 ? STATUS_RANGE : STATUS_OK);
					end else begin
						secs_q   <= 32'd0;
						acc_q    <= 32'(base_c);
						status_q <= bad1 ? STATUS_RANGE : STATUS_OK;
						yoff_q   <= yoff_c;
						mon_q    <= req.month_in;
						day_q    <= req.day_in;
						hour_q   <= req.hour_in;
						min_q    <= req.minute_in;
						sec_q    <= req.second_in;
						tod_q    <= tod_c;
					end
				end
			end
			ST_DAYS: begin
				if (ge) acc_q <= sum_w[31:0];
				if (last) begin
					dn_q <= {q_q, ge};
					q_q  <= 15'd0;
				end else begin
					q_q <= {q_q[13:0], ge};
				end
			end
			ST_HOURS: begin
				if (ge) acc_q <= sum_w[31:0];
				if (last) begin
					hour_q <= {q_q[3:0], ge};
					q_q    <= 15'd0;
				end else begin
					q_q <= {q_q[13:0], ge};
				end
			end
			ST_MINS: begin
				if (last) begin
					min_q <= {q_q[4:0], ge};
					sec_q <= ge ? sum_w[5:0] : acc_q[5:0];
					acc_q <= 32'(dn_q);
					q_q   <= 15'd0;
				end else begin
					if (ge) acc_q <= sum_w[31:0];
					q_q <= {q_q[13:0], ge};
				end
			end
			ST_QUAD: begin
				if (ge) acc_q <= sum_w[31:0];
				q_q <= {q_q[13:0], ge};
				if (last) begin
					yoff_q <= {q_q[3:0], ge, 2'b00};
				end
			end
			ST_YEARS: begin
				if (ge) begin
					acc_q  <= sum_w[31:0];
					yoff_q <= yoff_q + 7'd1;
				end else begin
					mon_q <= 4'd1;
				end
			end
			ST_MONTHS: begin
				if (mon_q < MONTHS && ge) begin
					acc_q <= sum_w[31:0];
					mon_q <= mon_q + 4'd1;
				end else begin
					day_q <= acc_q[4:0] + 5'd1;
					acc_q <= 32'(dn_q) + 32'd6;
				end
			end
			ST_SUMMON: begin
				if (cnt_q < {1'b0, mon_q}) begin
					acc_q <= sum_w[31:0];
				end else begin
					dn_q <= acc_q[15:0];
				end
			end
			ST_MUL:  acc_q <= 32'(dn_q) * SECS_PER_DAY;
			ST_ADDT: acc_q <= sum_w[31:0];
			ST_ADDE: begin
				secs_q <= sum_w[31:0];
				acc_q  <= 32'(dn_q) + 32'd6;
			end
			ST_WDAY: begin
				if (ge) acc_q <= sum_w[31:0];
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ECCU_ASSERT_NXT(a_accept_leaves_idle, accept, state_q != ST_IDLE)
	`ECCU_ASSERT_NXT(a_rsp_drains, rsp_valid && rsp_ready && state_q != ST_DONE, !rsp_valid)
	`ECCU_ASSERT_IMP(a_ok_month, rsp_valid && rsp.status == STATUS_OK, rsp.month_out >= 4'd1 && rsp.month_out <= MONTHS)
	`ECCU_ASSERT_IMP(a_unset_fields, rsp_valid && rsp.status != STATUS_OK, rsp.year_out == FIRST_YEAR && rsp.hour_twelve == 4'd12)

endmodule

@@ test/epoch_calendar_converter_unit_tb.sv @@
// ----------------------------------------------------------------------------
// epoch calendar converter unit testbench
// drives seconds-to-calendar and calendar-to-seconds requests with random
// idle gaps on both channels; a scoreboard predicts every response and
// compares it field by field in order of acceptance
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module epoch_calendar_converter_unit_tb
	import eccu_pkg::*;
();

	localparam int unsigned UNIX_AT_2000  = 32'd946684800;
	localparam int unsigned UNIX_AT_2100  = 32'd4102444799;
	localparam int unsigned DAY_SECONDS   = 86400;
	localparam int unsigned RANDOM_COUNT  = 1025;
	localparam int unsigned DRAIN_CYCLES  = 100;

	class conversion_scoreboard;
		rsp_t        pending_results[$];
		int unsigned failures;
		int unsigned checked;
		int unsigned to_cal_count;
		int unsigned to_secs_count;
		int unsigned flagged_count;

		function new();
			failures = 0;
			checked = 0;
			to_cal_count = 0;
			to_secs_count = 0;
			flagged_count = 0;
		endfunction

		function int unsigned month_length(int unsigned yoff, int unsigned mon);
			int unsigned len;
			case (mon)
				2:              len = (yoff % 4 == 0) ? 29 : 28;
				4, 6, 9, 11:    len = 30;
				1, 3, 5, 7, 8, 10, 12: len = 31;
				default:        len = 0;
			endcase
			return len;
		endfunction

		function int unsigned days_since_2000(int unsigned yoff, int unsigned mon,
			int unsigned dy);
			int unsigned total;
			total = dy - 1;
			for (int unsigned i = 1; i < mon; i++) begin
				total += month_length(yoff, i);
			end
			return total + 365 * yoff + (yoff + 3) / 4;
		endfunction

		function rsp_t expected_conversion(req_t r);
			rsp_t        e;
			int unsigned t;
			int unsigned days;
			int unsigned yoff;
			int unsigned mon;
			int unsigned dy;
			int unsigned hr;
			int unsigned mi;
			int unsigned sc;
			int unsigned len;
			int unsigned dn;
			bit          bad;
			e = '0;
			e.year_out = 12'd2000;
			e.hour_twelve = 4'd12;
			if (r.opcode == OP_TO_CAL) begin
				e.seconds_out = r.seconds_in;
				if (r.seconds_in == 0) begin
					e.status = STATUS_UNSET;
					return e;
				end
				if (r.seconds_in < UNIX_AT_2000 || r.seconds_in > UNIX_AT_2100) begin
					e.status = STATUS_RANGE;
					return e;
				end
				t = r.seconds_in - UNIX_AT_2000;
				sc = t % 60;
				t = t / 60;
				mi = t % 60;
				t = t / 60;
				hr = t % 24;
				days = t / 24;
				for (yoff = 0; yoff < 99; yoff++) begin
					len = (yoff % 4 == 0) ? 366 : 365;
					if (days < len) break;
					days -= len;
				end
				for (mon = 1; mon < 12; mon++) begin
					len = month_length(yoff, mon);
					if (days < len) break;
					days -= len;
				end
				dy = days + 1;
			end else begin
				mon = 32'(r.month_in);
				dy = 32'(r.day_in);
				hr = 32'(r.hour_in);
				mi = 32'(r.minute_in);
				sc = 32'(r.second_in);
				bad = (r.year_in < 2000 || r.year_in > 2099);
				yoff = bad ? 0 : r.year_in - 2000;
				if (mon < 1 || mon > 12) bad = 1'b1;
				if (dy < 1 || dy > month_length(yoff, mon)) bad = 1'b1;
				if (hr > 23 || mi > 59 || sc > 59) bad = 1'b1;
				if (bad) begin
					e.status = STATUS_RANGE;
					return e;
				end
				e.seconds_out = days_since_2000(yoff, mon, dy) * DAY_SECONDS
					+ hr * 3600 + mi * 60 + sc + UNIX_AT_2000;
			end
			dn = days_since_2000(yoff, mon, dy);
			e.status = STATUS_OK;
			e.year_out = 12'(2000 + yoff);
			e.month_out = 4'(mon);
			e.day_out = 5'(dy);
			e.hour_out = 5'(hr);
			e.minute_out = 6'(mi);
			e.second_out = 6'(sc);
			e.weekday = 3'((dn + 6) % 7);
			e.hour_twelve = 4'((hr == 0) ? 12 : ((hr > 12) ? hr - 12 : hr));
			e.after_noon = (hr >= 12);
			return e;
		endfunction

		function void note_request(req_t r);
			rsp_t e;
			e = expected_conversion(r);
			if (r.opcode == OP_TO_CAL) to_cal_count++;
			else to_secs_count++;
			if (e.status != STATUS_OK) flagged_count++;
			pending_results.push_back(e);
		endfunction

		function void compare_field(string field, longint unsigned want,
			longint unsigned got);
			if (want != got) begin
				failures++;
				$display("%0t: %s mismatch, expected %0d, actual %0d",
					$time, field, want, got);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending_results.size() == 0) begin
				failures++;
				$display("%0t: unexpected transaction, expected none, actual %h",
					$time, got);
				return;
			end
			want = pending_results.pop_front();
			checked++;
			compare_field("status", 64'(want.status), 64'(got.status));
			compare_field("seconds_out", 64'(want.seconds_out), 64'(got.seconds_out));
			compare_field("year_out", 64'(want.year_out), 64'(got.year_out));
			compare_field("month_out", 64'(want.month_out), 64'(got.month_out));
			compare_field("day_out", 64'(want.day_out), 64'(got.day_out));
			compare_field("hour_out", 64'(want.hour_out), 64'(got.hour_out));
			compare_field("minute_out", 64'(want.minute_out), 64'(got.minute_out));
			compare_field("second_out", 64'(want.second_out), 64'(got.second_out));
			compare_field("weekday", 64'(want.weekday), 64'(got.weekday));
			compare_field("hour_twelve", 64'(want.hour_twelve), 64'(got.hour_twelve));
			compare_field("after_noon", 64'(want.after_noon), 64'(got.after_noon));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	req_t req;
	logic rsp_valid;
	logic rsp_ready;
	rsp_t rsp;

	conversion_scoreboard sb;
	int unsigned          send_calm;
	int unsigned          recv_calm;

	epoch_calendar_converter_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// idle stretches alternate with runs of back-to-back transactions
	function automatic int unsigned idle_cycles(ref int unsigned calm_left);
		if (calm_left > 0) begin
			calm_left--;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm_left = $urandom_range(8, 40);
			return 0;
		end
		return $urandom_range(0, 13);
	endfunction

	function automatic req_t noise_request();
		req_t r;
		r.opcode = 1'($urandom_range(0, 1));
		r.seconds_in = $urandom;
		r.year_in = 12'($urandom);
		r.month_in = 4'($urandom);
		r.day_in = 5'($urandom);
		r.hour_in = 5'($urandom);
		r.minute_in = 6'($urandom);
		r.second_in = 6'($urandom);
		return r;
	endfunction

	function automatic req_t secs_request(logic [31:0] value);
		req_t r;
		r = noise_request();
		r.opcode = OP_TO_CAL;
		r.seconds_in = value;
		return r;
	endfunction

	function automatic req_t cal_request(int unsigned y, int unsigned m, int unsigned d,
		int unsigned h, int unsigned mi, int unsigned s);
		req_t r;
		r = noise_request();
		r.opcode = OP_TO_SECS;
		r.year_in = 12'(y);
		r.month_in = 4'(m);
		r.day_in = 5'(d);
		r.hour_in = 5'(h);
		r.minute_in = 6'(mi);
		r.second_in = 6'(s);
		return r;
	endfunction

	function automatic req_t random_request();
		req_t        r;
		int unsigned kind;
		int unsigned y;
		int unsigned m;
		kind = $urandom_range(0, 99);
		if (kind < 40) begin
			r = secs_request($urandom_range(UNIX_AT_2000, UNIX_AT_2100));
		end else if (kind < 80) begin
			y = $urandom_range(2000, 2099);
			m = $urandom_range(1, 12);
			r = cal_request(y, m, $urandom_range(1, sb.month_length(y - 2000, m)),
				$urandom_range(0, 23), $urandom_range(0, 59), $urandom_range(0, 59));
		end else if (kind < 86) begin
			r = secs_request($urandom);
		end else if (kind < 90) begin
			if ($urandom_range(0, 1))
				r = secs_request(UNIX_AT_2000 - 8 + $urandom_range(0, 15));
			else
				r = secs_request(UNIX_AT_2100 - 8 + $urandom_range(0, 15));
		end else if (kind < 96) begin
			// one calendar field pushed past its limit
			y = $urandom_range(2000, 2099);
			m = $urandom_range(1, 12);
			r = cal_request(y, m, sb.month_length(y - 2000, m), 12, 30, 30);
			case ($urandom_range(0, 5))
				0: r.year_in = 12'($urandom_range(0, 1) ? $urandom_range(2100, 4095)
					: $urandom_range(0, 1999));
				1: r.month_in = 4'($urandom_range(0, 1) ? 0 : $urandom_range(13, 15));
				2: r.day_in = 5'($urandom_range(0, 1) ? 0
					: $urandom_range(sb.month_length(y - 2000, m) + 1, 31));
				3: r.hour_in = 5'($urandom_range(24, 31));
				4: r.minute_in = 6'($urandom_range(60, 63));
				default: r.second_in = 6'($urandom_range(60, 63));
			endcase
		end else begin
			r = noise_request();
		end
		return r;
	endfunction

	task automatic send_request(input req_t r);
		int unsigned gap;
		gap = idle_cycles(send_calm);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req <= r;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic receive_results();
		int unsigned gap;
		forever begin
			gap = idle_cycles(recv_calm);
			if (gap > 0) begin
				rsp_ready <= 1'b0;
				// half the stalls start only once a response is waiting
				if ($urandom_range(0, 1)) begin
					@(posedge clk);
					while (!rsp_valid) @(posedge clk);
					gap--;
				end
				repeat (gap) @(posedge clk);
			end
			rsp_ready <= 1'b1;
			@(posedge clk);
			while (!rsp_valid) @(posedge clk);
			sb.check_result(rsp);
		end
	endtask

	initial begin
		req_t directed[$];
		sb = new();
		send_calm = 0;
		recv_calm = 0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		rsp_ready = 1'b0;
		req = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			receive_results();
		join_none

		directed.push_back(secs_request(32'd0));
		directed.push_back(secs_request(32'd1));
		directed.push_back(secs_request(UNIX_AT_2000 - 1));
		directed.push_back(secs_request(UNIX_AT_2000));
		directed.push_back(secs_request(32'd951782400));
		directed.push_back(secs_request(32'd978307199));
		directed.push_back(secs_request(32'd1234567890));
		directed.push_back(secs_request(UNIX_AT_2100));
		directed.push_back(secs_request(UNIX_AT_2100 + 1));
		directed.push_back(secs_request(32'hFFFF_FFFF));
		directed.push_back(cal_request(2000, 1, 1, 0, 0, 0));
		directed.push_back(cal_request(2099, 12, 31, 23, 59, 59));
		directed.push_back(cal_request(2004, 2, 29, 12, 30, 0));
		directed.push_back(cal_request(2050, 7, 4, 13, 45, 30));
		directed.push_back(cal_request(2001, 2, 29, 8, 0, 0));
		directed.push_back(cal_request(1999, 12, 31, 23, 59, 59));
		directed.push_back(cal_request(2100, 1, 1, 0, 0, 0));
		directed.push_back(cal_request(4095, 15, 31, 31, 63, 63));
		directed.push_back(cal_request(0, 0, 0, 0, 0, 0));
		directed.push_back(cal_request(2020, 13, 1, 1, 1, 1));
		directed.push_back(cal_request(2020, 4, 31, 1, 1, 1));
		directed.push_back(cal_request(2020, 6, 15, 24, 0, 0));
		directed.push_back(cal_request(2020, 6, 15, 11, 60, 0));
		directed.push_back(cal_request(2020, 6, 15, 11, 0, 60));

		foreach (directed[i]) send_request(directed[i]);
		for (int unsigned n = 0; n < RANDOM_COUNT; n++) send_request(random_request());
		req_valid <= 1'b0;

		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.pending_results.size() != 0) sb.failures++;

		$display("checked %0d conversions: %0d seconds to calendar, %0d calendar to seconds",
			sb.checked, sb.to_cal_count, sb.to_secs_count);
		$display("%0d of them zero or out of range, with random stalls on both channels",
			sb.flagged_count);
		if (sb.failures == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/eccu_pkg.sv
hw/rtl/epoch_calendar_converter_unit.sv
test/epoch_calendar_converter_unit_tb.sv
